FILE: src/qbv_pkg.sv
// ----------------------------------------------------------------------------
// qbv_pkg: shared types and constants for the shortest-arc quaternion block
// Holds the payload structs, fixed-point constants and pipeline sizing.
// ----------------------------------------------------------------------------
package qbv_pkg;

	localparam int IN_WIDTH  = 16;
	localparam int FRAC_BITS = 14;
	localparam int OUT_WIDTH = 16;
	localparam int MARGIN_W  = 15;

	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 15'd16;
	localparam logic [15:0]         Q_ONE        = 16'(1 << FRAC_BITS);
	// squared axis length below which the second axis candidate is used
	localparam logic [31:0]         AXIS_MIN     = 32'((64'd1 << (2 * FRAC_BITS)) / 100);

	// square root pipeline: 32 result bits, SQ_BITS per stage
	localparam int SQ_BITS = 4;
	localparam int SQ_ST   = 32 / SQ_BITS;

	// rounding divider: 15 quotient bits, DV_BITS per stage
	localparam int QBITS   = 15;
	localparam int DV_BITS = 3;
	localparam int DV_ST   = QBITS / DV_BITS;
	localparam int NUM_W   = 46;
	localparam int DEN_W   = 32;

	typedef struct packed {
		logic signed [IN_WIDTH-1:0] from_x;
		logic signed [IN_WIDTH-1:0] from_y;
		logic signed [IN_WIDTH-1:0] from_z;
		logic signed [IN_WIDTH-1:0] to_x;
		logic signed [IN_WIDTH-1:0] to_y;
		logic signed [IN_WIDTH-1:0] to_z;
	} qbv_in_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] quat_w;
		logic signed [OUT_WIDTH-1:0] quat_x;
		logic signed [OUT_WIDTH-1:0] quat_y;
		logic signed [OUT_WIDTH-1:0] quat_z;
		logic                        half_turn;
		logic                        degenerate;
	} qbv_out_t;

endpackage

FILE: src/qbv_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// qbv_sqrt_pipe: pipelined integer square root
// Floor square root of a 64-bit radicand, SQ_BITS result bits per stage.
// ----------------------------------------------------------------------------
module qbv_sqrt_pipe import qbv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [63:0] radicand,
	output logic        out_valid,
	output logic [31:0] root
);

	typedef struct packed {
		logic [35:0] rem;
		logic [31:0] root;
		logic [63:0] rad;
	} sq_st_t;

	sq_st_t           st_s [SQ_ST];
	logic [SQ_ST-1:0] vld_s;
	sq_st_t           init;

	// one stage of digit-by-digit root extraction
	function automatic sq_st_t sq_step(sq_st_t a);
		sq_st_t      r;
		logic [35:0] cur;
		logic [35:0] trial;
		r = a;
		for (int t = 0; t < SQ_BITS; t++) begin
			cur   = {r.rem[33:0], r.rad[63:62]};
			trial = {2'b00, r.root, 2'b01};
			if (cur >= trial) begin
				r.rem  = cur - trial;
				r.root = {r.root[30:0], 1'b1};
			end else begin
				r.rem  = cur;
				r.root = {r.root[30:0], 1'b0};
			end
			r.rad = {r.rad[61:0], 2'b00};
		end
		return r;
	endfunction

	assign init = '{rem: '0, root: '0, rad: radicand};

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[SQ_ST-2:0], in_valid};
		end
	end

	// advance partial roots
	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= sq_step(init);
			for (int j = 1; j < SQ_ST; j++) begin
				st_s[j] <= sq_step(st_s[j-1]);
			end
		end
	end

	assign out_valid = vld_s[SQ_ST-1];
	assign root      = st_s[SQ_ST-1].root;

endmodule

FILE: src/qbv_div_pipe.sv
// ----------------------------------------------------------------------------
// qbv_div_pipe: pipelined rounding divider with unit saturation
// Sign-magnitude numerator over unsigned divisor, halves away from zero,
// result saturated to plus or minus one in Q1.14.
// ----------------------------------------------------------------------------
module qbv_div_pipe import qbv_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [NUM_W-1:0]     num_mag,
	input  logic                 num_neg,
	input  logic [DEN_W-1:0]     den,
	output logic                 out_valid,
	output logic signed [15:0]   quo
);

	localparam int REM_W = NUM_W + 1;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [QBITS-1:0] q;
		logic             sat;
		logic             neg;
	} dv_st_t;

	dv_st_t         st_s [DV_ST+1];
	logic [DV_ST:0] vld_s;
	dv_st_t         pre;
	logic [15:0]    mag;

	// DV_BITS restoring steps of stage j
	function automatic dv_st_t dv_step(dv_st_t a, int j);
		dv_st_t           r;
		logic [REM_W-1:0] dsh;
		r = a;
		for (int t = 0; t < DV_BITS; t++) begin
			dsh = {{(REM_W-DEN_W){1'b0}}, r.den} << (QBITS - 1 - j * DV_BITS - t);
			if (r.rem >= dsh) begin
				r.rem = r.rem - dsh;
				r.q   = {r.q[QBITS-2:0], 1'b1};
			end else begin
				r.q   = {r.q[QBITS-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	// add half the divisor for rounding, flag quotients that overflow
	always_comb begin
		pre.rem = {1'b0, num_mag} + {{(REM_W-DEN_W){1'b0}}, den >> 1};
		pre.den = den;
		pre.q   = '0;
		pre.sat = pre.rem >= {den, {QBITS{1'b0}}};
		pre.neg = num_neg;
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[DV_ST-1:0], in_valid};
		end
	end

	// advance partial quotients
	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= pre;
			for (int j = 0; j < DV_ST; j++) begin
				st_s[j+1] <= dv_step(st_s[j], j);
			end
		end
	end

	// clamp to one and apply sign
	always_comb begin
		if (st_s[DV_ST].sat || ({1'b0, st_s[DV_ST].q} > Q_ONE)) begin
			mag = Q_ONE;
		end else begin
			mag = {1'b0, st_s[DV_ST].q};
		end
		quo = st_s[DV_ST].neg ? (16'd0 - mag) : mag;
	end

	assign out_valid = vld_s[DV_ST];

endmodule

FILE: src/quaternion_between_vectors.sv
// ----------------------------------------------------------------------------
// quaternion_between_vectors: shortest-arc rotation quaternion, Q1.14
// Normalizes two integer vectors and returns the rotation between them.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one transaction: a source and a target vector.
//   out_valid/out_ready carry one transaction per input: quaternion (w,x,y,z)
//   in Q1.14 with the half_turn and degenerate flags.
//   cfg_wr_en/cfg_wr_data write the antiparallel margin; write only while
//   the block is empty.
// Pipeline: two front stages, a square root of 8 stages, a divider of 6
//   stages, a product stage, a stage holding the chosen root operand and
//   numerators, a second root and divider, then the output register.
// Throughput: one transaction per cycle while not stalled; every stage of the
//   square root and divider pipelines takes a new item each cycle it advances.
// Reset: all stages empty, margin returns to 16.
// Stall: while out_valid is high and out_ready low, the whole pipeline
//   holds and in_ready is low; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module quaternion_between_vectors import qbv_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  qbv_in_t             in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output qbv_out_t            out_data,
	input  logic                cfg_wr_en,
	input  logic [MARGIN_W-1:0] cfg_wr_data
);

	typedef struct packed {
		logic [2:0][15:0] v;
		logic [2:0][30:0] sq;
		logic [4:0]       k;
		logic             zero;
	} vec1_t;

	typedef struct packed {
		logic [2:0][15:0] va;
		logic [4:0]       ka;
		logic [2:0][15:0] vb;
		logic [4:0]       kb;
		logic             degen;
	} side2_t;

	typedef struct packed {
		logic [2:0][NUM_W-1:0] num;
		logic [2:0]            neg;
		logic                  half;
		logic                  degen;
	} side4_t;

	typedef struct packed {
		logic [15:0] w;
		logic        half;
		logic        degen;
		logic        zlen;
	} side5_t;

	logic [MARGIN_W-1:0] margin_q;
	logic                adv;

	vec1_t               fa, fb;
	vec1_t               va_s1, vb_s1;
	logic                v1_s1;
	side2_t              side2_s2;
	logic [63:0]         rada_s2, radb_s2;
	logic                v2_s2;

	logic [31:0]         lena, lenb;
	logic                sqa_vld, sqb_vld;
	side2_t              dl1_s [SQ_ST];
	side2_t              sd1;

	logic [2:0][15:0]    ua, ub;
	logic [5:0]          uvld;
	logic [DV_ST:0]      dl2_s;

	logic signed [31:0]  dot_s3 [3];
	logic signed [31:0]  crs_s3 [6];
	logic signed [31:0]  usq_s3 [3];
	logic [2:0][15:0]    ua_s3;
	logic                degen_s3;
	logic                v3_s3;

	logic signed [31:0]  dsum, thr, pval;
	logic signed [31:0]  cr [3];
	logic [31:0]         len2a, len2;
	logic                alt, half;
	side4_t              side4_c;
	logic [63:0]         rad_c;
	side4_t              side4_s4;
	logic [63:0]         rad_s4;
	logic                v4_s4;

	logic [31:0]         rootf;
	logic                sqf_vld;
	side4_t              dl3_s [SQ_ST];
	side4_t              sd3;
	side5_t              side5_c;
	side5_t              dl4_s [DV_ST+1];
	side5_t              sd4;
	logic [32:0]         r1;

	logic [2:0][15:0]    qf;
	logic [2:0]          fvld;

	logic                out_valid_q;
	qbv_out_t            out_data_q;

	// magnitude of a 16-bit signed value
	function automatic logic [16:0] umag(logic [15:0] v);
		return v[15] ? (17'd0 - {v[15], v}) : {1'b0, v};
	endfunction

	// magnitude of a 32-bit signed value, widened to numerator width
	function automatic logic [NUM_W-1:0] wmag(logic [31:0] v);
		logic [32:0] m;
		m = v[31] ? (33'd0 - {v[31], v}) : {1'b0, v};
		return {{(NUM_W-33){1'b0}}, m};
	endfunction

	// squares, shift to bring the largest part into [2^30, 2^31), zero flag
	function automatic vec1_t front(logic [2:0][15:0] v);
		vec1_t            r;
		logic [2:0][16:0] mg;
		logic [16:0]      m;
		logic [4:0]       p;
		m = '0;
		p = '0;
		for (int i = 0; i < 3; i++) begin
			mg[i]   = umag(v[i]);
			r.sq[i] = 31'({14'd0, mg[i]} * {14'd0, mg[i]});
			if (mg[i] > m) begin
				m = mg[i];
			end
		end
		for (int b = 0; b < 17; b++) begin
			if (m[b]) begin
				p = 5'(b);
			end
		end
		r.v    = v;
		r.k    = 5'd30 - p;
		r.zero = (m == '0);
		return r;
	endfunction

	// numerator of a unit component: |v| << (k + FRAC_BITS)
	function automatic logic [NUM_W-1:0] unum(logic [15:0] v, logic [4:0] k);
		logic [5:0] sh;
		sh = {1'b0, k} + 6'(FRAC_BITS);
		return {{(NUM_W-17){1'b0}}, umag(v)} << sh;
	endfunction

	// numerator of an axis component: |u| << FRAC_BITS
	function automatic logic [NUM_W-1:0] anum(logic [15:0] u);
		return {{(NUM_W-17){1'b0}}, umag(u)} << FRAC_BITS;
	endfunction

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// hold the margin register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MARGIN_RESET;
		end else if (cfg_wr_en) begin
			margin_q <= cfg_wr_data;
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else if (adv) begin
			v1_s1 <= in_valid;
			v2_s2 <= v1_s1;
			v3_s3 <= &uvld;
			v4_s4 <= v3_s3;
		end
	end

	assign fa = front({in_data.from_z, in_data.from_y, in_data.from_x});
	assign fb = front({in_data.to_z, in_data.to_y, in_data.to_x});

	// front stages: squares, then shifted sum of squares
	always_ff @(posedge clk) begin
		if (adv) begin
			va_s1          <= fa;
			vb_s1          <= fb;
			rada_s2        <= {31'd0, {2'b0, va_s1.sq[0]} + {2'b0, va_s1.sq[1]}
			                  + {2'b0, va_s1.sq[2]}} << {va_s1.k, 1'b0};
			radb_s2        <= {31'd0, {2'b0, vb_s1.sq[0]} + {2'b0, vb_s1.sq[1]}
			                  + {2'b0, vb_s1.sq[2]}} << {vb_s1.k, 1'b0};
			side2_s2.va    <= va_s1.v;
			side2_s2.ka    <= va_s1.k;
			side2_s2.vb    <= vb_s1.v;
			side2_s2.kb    <= vb_s1.k;
			side2_s2.degen <= va_s1.zero || vb_s1.zero;
		end
	end

	qbv_sqrt_pipe u_sqrt_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v2_s2),
		.radicand  (rada_s2),
		.out_valid (sqa_vld),
		.root      (lena)
	);

	qbv_sqrt_pipe u_sqrt_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v2_s2),
		.radicand  (radb_s2),
		.out_valid (sqb_vld),
		.root      (lenb)
	);

	// delay vectors alongside the length roots
	always_ff @(posedge clk) begin
		if (adv) begin
			dl1_s[0] <= side2_s2;
			for (int j = 1; j < SQ_ST; j++) begin
				dl1_s[j] <= dl1_s[j-1];
			end
		end
	end
	assign sd1 = dl1_s[SQ_ST-1];

	for (genvar i = 0; i < 3; i++) begin : g_unit
		qbv_div_pipe u_div_a (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (sqa_vld && sqb_vld),
			.num_mag   (unum(sd1.va[i], sd1.ka)),
			.num_neg   (sd1.va[i][15]),
			.den       (lena),
			.out_valid (uvld[i]),
			.quo       (ua[i])
		);
		qbv_div_pipe u_div_b (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (sqa_vld && sqb_vld),
			.num_mag   (unum(sd1.vb[i], sd1.kb)),
			.num_neg   (sd1.vb[i][15]),
			.den       (lenb),
			.out_valid (uvld[i+3]),
			.quo       (ub[i])
		);
	end

	// delay the degenerate flag alongside the unit dividers
	always_ff @(posedge clk) begin
		if (adv) begin
			dl2_s <= {dl2_s[DV_ST-1:0], sd1.degen};
		end
	end

	// products of the unit vectors
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dot_s3[i] <= $signed(ua[i]) * $signed(ub[i]);
				usq_s3[i] <= $signed(ua[i]) * $signed(ua[i]);
			end
			crs_s3[0] <= $signed(ua[1]) * $signed(ub[2]);
			crs_s3[1] <= $signed(ua[2]) * $signed(ub[1]);
			crs_s3[2] <= $signed(ua[2]) * $signed(ub[0]);
			crs_s3[3] <= $signed(ua[0]) * $signed(ub[2]);
			crs_s3[4] <= $signed(ua[0]) * $signed(ub[1]);
			crs_s3[5] <= $signed(ua[1]) * $signed(ub[0]);
			ua_s3     <= ua;
			degen_s3  <= dl2_s[DV_ST];
		end
	end

	// choose the path, the root operand and the numerators
	always_comb begin
		dsum  = dot_s3[0] + dot_s3[1] + dot_s3[2];
		thr   = ($signed({17'd0, margin_q}) - 32'sd16384) <<< FRAC_BITS;
		pval  = dsum + (32'sd1 <<< (2 * FRAC_BITS));
		half  = (dsum < thr) || (pval <= 32'sd0);
		cr[0] = crs_s3[0] - crs_s3[1];
		cr[1] = crs_s3[2] - crs_s3[3];
		cr[2] = crs_s3[4] - crs_s3[5];
		len2a = 32'(usq_s3[0]) + 32'(usq_s3[1]);
		alt   = len2a < AXIS_MIN;
		len2  = alt ? (32'(usq_s3[1]) + 32'(usq_s3[2])) : len2a;
		if (half) begin
			rad_c = {32'd0, len2};
			if (alt) begin
				side4_c.num = {anum(ua_s3[1]), anum(ua_s3[2]), {NUM_W{1'b0}}};
				side4_c.neg = {ua_s3[1][15], !ua_s3[2][15], 1'b0};
			end else begin
				side4_c.num = {{NUM_W{1'b0}}, anum(ua_s3[0]), anum(ua_s3[1])};
				side4_c.neg = {1'b0, ua_s3[0][15], !ua_s3[1][15]};
			end
		end else begin
			rad_c       = {31'd0, pval, 1'b0};
			side4_c.num = {wmag(cr[2]), wmag(cr[1]), wmag(cr[0])};
			side4_c.neg = {cr[2][31], cr[1][31], cr[0][31]};
		end
		side4_c.half  = half;
		side4_c.degen = degen_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s4   <= rad_c;
			side4_s4 <= side4_c;
		end
	end

	qbv_sqrt_pipe u_sqrt_f (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v4_s4),
		.radicand  (rad_s4),
		.out_valid (sqf_vld),
		.root      (rootf)
	);

	// delay numerators alongside the final root
	always_ff @(posedge clk) begin
		if (adv) begin
			dl3_s[0] <= side4_s4;
			for (int j = 1; j < SQ_ST; j++) begin
				dl3_s[j] <= dl3_s[j-1];
			end
		end
	end
	assign sd3 = dl3_s[SQ_ST-1];

	// scalar part from the root
	always_comb begin
		r1            = ({1'b0, rootf} + 33'd1) >> 1;
		side5_c.half  = sd3.half;
		side5_c.degen = sd3.degen;
		side5_c.zlen  = (rootf == '0);
		if (sd3.half) begin
			side5_c.w = '0;
		end else if (r1 > {17'd0, Q_ONE}) begin
			side5_c.w = Q_ONE;
		end else begin
			side5_c.w = r1[15:0];
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_final
		qbv_div_pipe u_div_f (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (sqf_vld),
			.num_mag   (sd3.num[i]),
			.num_neg   (sd3.neg[i]),
			.den       (rootf),
			.out_valid (fvld[i]),
			.quo       (qf[i])
		);
	end

	// delay scalar part and flags alongside the final dividers
	always_ff @(posedge clk) begin
		if (adv) begin
			dl4_s[0] <= side5_c;
			for (int j = 1; j <= DV_ST; j++) begin
				dl4_s[j] <= dl4_s[j-1];
			end
		end
	end
	assign sd4 = dl4_s[DV_ST];

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= &fvld;
		end
	end

	// assemble the result transaction
	always_ff @(posedge clk) begin
		if (adv) begin
			if (sd4.degen) begin
				out_data_q <= '{quat_w: Q_ONE, quat_x: '0, quat_y: '0, quat_z: '0,
				                half_turn: 1'b0, degenerate: 1'b1};
			end else if (sd4.half && sd4.zlen) begin
				out_data_q <= '{quat_w: '0, quat_x: Q_ONE, quat_y: '0, quat_z: '0,
				                half_turn: 1'b1, degenerate: 1'b0};
			end else begin
				out_data_q <= '{quat_w: sd4.w, quat_x: qf[0], quat_y: qf[1], quat_z: qf[2],
				                half_turn: sd4.half, degenerate: 1'b0};
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	a_degen_identity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.degenerate |->
			out_data.quat_w == $signed(Q_ONE) && !out_data.half_turn)
		else $error("degenerate result is not the identity");

	a_half_zero_w: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.half_turn |-> out_data.quat_w == 16'sd0)
		else $error("half turn with nonzero scalar part");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.quat_x <= $signed(Q_ONE) && out_data.quat_x >= -$signed(Q_ONE)
			&& out_data.quat_w <= $signed(Q_ONE) && out_data.quat_w >= 16'sd0)
		else $error("quaternion part out of unit range");
`endif

endmodule
